>>> hw/rtl/hbk_pkg.sv
package hbk_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int CODE_W    = 8;

  // Depth of the queue between the classifier and the event emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CODE_W-1:0] code_t;
  typedef code_t [KEY_SLOTS-1:0] slots_t;
  typedef logic [KEY_SLOTS-1:0] slot_mask_t;

  // One classified report: its codes and which slots are new presses
  typedef struct packed {
    slots_t     codes;
    slot_mask_t press;
  } entry_t;

  localparam code_t CODE_EMPTY = '0;

endpackage

>>> hw/rtl/hbk_report_if.sv
interface hbk_report_if;
  logic          valid;
  logic          ready;
  hbk_pkg::code_t key_slot_0;
  hbk_pkg::code_t key_slot_1;
  hbk_pkg::code_t key_slot_2;
  hbk_pkg::code_t key_slot_3;
  hbk_pkg::code_t key_slot_4;
  hbk_pkg::code_t key_slot_5;

  modport source (
    output valid, key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    input  ready
  );
  modport sink (
    input  valid, key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    output ready
  );
endinterface

>>> hw/rtl/hbk_event_if.sv
interface hbk_event_if;
  logic           valid;
  logic           ready;
  hbk_pkg::code_t pressed_code;
  logic           last_event;

  modport source (
    output valid, pressed_code, last_event,
    input  ready
  );
  modport sink (
    input  valid, pressed_code, last_event,
    output ready
  );
endinterface

>>> hw/rtl/hbk_front.sv
module hbk_front (
  input  logic            clk,
  input  logic            rst,
  hbk_report_if.sink      report,
  input  logic            queue_full,
  output logic            push,
  output hbk_pkg::entry_t entry
);

  hbk_pkg::slots_t     now;
  hbk_pkg::slots_t     prev;
  hbk_pkg::slot_mask_t press;
  logic                accept;

  assign now[0] = report.key_slot_0;
  assign now[1] = report.key_slot_1;
  assign now[2] = report.key_slot_2;
  assign now[3] = report.key_slot_3;
  assign now[4] = report.key_slot_4;
  assign now[5] = report.key_slot_5;

  // The held-key map always equals the set of nonzero codes of the previous
  // report, so a slot is a new press when its code is nonzero, absent from
  // the previous report and not repeated in an earlier slot.
  always_comb begin
    logic held;
    logic dup;
    for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++) begin
      held = 1'b0;
      dup  = 1'b0;
      for (int j = 0; j < hbk_pkg::KEY_SLOTS; j++) begin
        if (prev[j] == now[i]) held = 1'b1;
        if (j < i && now[j] == now[i]) dup = 1'b1;
      end
      press[i] = (now[i] != hbk_pkg::CODE_EMPTY) && !held && !dup;
    end
  end

  assign report.ready = !queue_full;
  assign accept       = report.valid && report.ready;
  assign push         = accept && (press != '0);
  assign entry.codes  = now;
  assign entry.press  = press;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (accept) begin
      prev <= now;
    end
  end

  a_prev_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> prev == $past(now))
    else $error("previous report not captured");

endmodule

>>> hw/rtl/hbk_queue.sv
module hbk_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hbk_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output hbk_pkg::entry_t rd_entry
);

  hbk_pkg::entry_t                   mem [hbk_pkg::QUEUE_DEPTH];
  logic [hbk_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [hbk_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [hbk_pkg::QUEUE_CNT_W-1:0]   count;
  logic                              do_push;
  logic                              do_pop;

  assign full     = (count == hbk_pkg::QUEUE_CNT_W'(hbk_pkg::QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign rd_entry = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= hbk_pkg::QUEUE_CNT_W'(hbk_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

>>> hw/rtl/hbk_back.sv
module hbk_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  hbk_pkg::entry_t q_entry,
  output logic            pop,
  hbk_event_if.source     press
);

  logic                cur_valid;
  hbk_pkg::slots_t     cur_codes;
  hbk_pkg::slot_mask_t cur_mask;
  hbk_pkg::slot_mask_t low_bit;
  hbk_pkg::slot_mask_t rem;
  hbk_pkg::code_t      sel_code;
  logic                out_valid;
  hbk_pkg::code_t      out_code;
  logic                out_last;
  logic                out_free;
  logic                emit;
  logic                cur_done;

  assign low_bit = cur_mask & (~cur_mask + 1'b1);
  assign rem     = cur_mask & ~low_bit;

  always_comb begin
    sel_code = '0;
    for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++) begin
      if (low_bit[i]) sel_code = sel_code | cur_codes[i];
    end
  end

  assign out_free = !out_valid || press.ready;
  assign emit     = cur_valid && (cur_mask != '0) && out_free;
  assign cur_done = cur_valid && ((cur_mask == '0) || (emit && rem == '0));
  assign pop      = q_valid && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (press.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_codes <= q_entry.codes;
      cur_mask  <= q_entry.press;
    end else if (emit) begin
      cur_mask <= rem;
    end
    if (emit) begin
      out_code <= sel_code;
      out_last <= (rem == '0);
    end
  end

  assign press.valid        = out_valid;
  assign press.pressed_code = out_code;
  assign press.last_event   = out_last;

  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_code != hbk_pkg::CODE_EMPTY)
    else $error("empty code emitted as press");

  a_more_events: assert property (@(posedge clk) disable iff (rst)
    (emit && rem != '0) |=> cur_valid && !out_last)
    else $error("report dropped before its last event");

endmodule

>>> hw/rtl/hid_boot_key_press_detect.sv
// First press event path: report -> queue entry -> current register -> output register.
// Throughput: one report transaction per cycle while the 4-entry queue has room;
//   the emitter gives one event per cycle while the event sink is ready, so a report
//   with k new presses gives k events (at most 6). Reports with no new press use no slot.
// Reset (rst, synchronous): previous report cleared to all empty slots, no key
//   held, queue and output register emptied.
module hid_boot_key_press_detect (
  input  logic       clk,
  input  logic       rst,
  hbk_report_if.sink  report,
  hbk_event_if.source press
);

  // Front: compares the report with the previous one and marks new presses.
  // Queue: buffers classified reports so the front keeps taking transactions
  //   while the emitter is stalled by the event sink.
  // Back: walks the press mask lowest slot first, one event per cycle while the sink is
  //   ready, with an output register so a waiting event does not block the next pop.
  logic            push;
  logic            full;
  logic            pop;
  logic            q_valid;
  hbk_pkg::entry_t wr_entry;
  hbk_pkg::entry_t rd_entry;

  hbk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .report     (report),
    .queue_full (full),
    .push       (push),
    .entry      (wr_entry)
  );

  hbk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .rd_entry (rd_entry)
  );

  hbk_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (rd_entry),
    .pop     (pop),
    .press   (press)
  );

endmodule
